// ----- rtl/srrd_pkg.sv -----
// Shared types and constants for the sparse run row decoder.
// Used by every module in rtl/; depends on nothing.
package srrd_pkg;

  localparam logic [7:0] EscByte   = 8'hFF;
  localparam logic [7:0] LongMark  = 8'h00;
  localparam logic [8:0] EscOffset = 9'd255;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_LINE_WIDTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_FG_COLOUR  = 1'b1;

  localparam logic [9:0]  LineWidthReset = 10'd320;
  localparam logic [15:0] FgColourReset  = 16'hFFFF;

  localparam int QueueDepth = 2;
  localparam int NumSlots   = 5;
  // slots 0, 2, 4 are blank fills, slots 1, 3 colour fills
  localparam logic [NumSlots-1:0] BlankSlots = 5'b10101;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_in_row;
    logic       row_empty;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  fill_count;
    logic [15:0] fill_value;
    logic        is_blank;
    logic        row_done;
    logic        last;
  } out_item_t;

  // classified item: up to two runs, then optional row end
  typedef struct packed {
    logic       empty;
    logic       row_end;
    logic       r0_v;
    logic [8:0] r0_x;
    logic [7:0] r0_len;
    logic       r1_v;
    logic [8:0] r1_x;
  } cmd_t;

  typedef enum logic [3:0] {
    PH_START     = 4'b0001,
    PH_AFTER_ESC = 4'b0010,
    PH_HELD      = 4'b0100,
    PH_LEN       = 4'b1000
  } phase_t;

endpackage

// ----- rtl/srrd_front.sv -----
// Front end: parses code bytes into run commands, tracks entry phase.
// Depends on srrd_pkg.
module srrd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  srrd_pkg::in_item_t in_item,
  input  logic              push,
  output srrd_pkg::cmd_t    cmd
);

  srrd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       hc_r, hc_nxt;
  logic [8:0] off;
  logic [7:0] b;

  assign b   = in_item.code_byte;
  assign off = hc_r ? srrd_pkg::EscOffset : 9'd0;

  always_comb begin
    cmd       = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    hc_nxt    = hc_r;
    if (in_item.row_empty) begin
      cmd.empty = 1'b1;
      phase_nxt = srrd_pkg::PH_START;
      held_nxt  = 8'd0;
      hc_nxt    = 1'b0;
    end else begin
      case (phase_r)
        srrd_pkg::PH_START: begin
          if (b == srrd_pkg::EscByte) begin
            hc_nxt    = 1'b1;
            phase_nxt = srrd_pkg::PH_AFTER_ESC;
          end else begin
            held_nxt = b;
            if (in_item.last_in_row) begin
              cmd.r0_v   = 1'b1;
              cmd.r0_x   = {1'b0, b} + off;
              cmd.r0_len = 8'd1;
            end else begin
              phase_nxt = srrd_pkg::PH_HELD;
            end
          end
        end
        srrd_pkg::PH_AFTER_ESC: begin
          held_nxt = b;
          if (in_item.last_in_row) begin
            cmd.r0_v   = 1'b1;
            cmd.r0_x   = {1'b0, b} + off;
            cmd.r0_len = 8'd1;
          end else begin
            phase_nxt = srrd_pkg::PH_HELD;
          end
        end
        srrd_pkg::PH_HELD: begin
          if (b > held_r) begin
            cmd.r0_v   = 1'b1;
            cmd.r0_x   = {1'b0, held_r} + off;
            cmd.r0_len = 8'd1;
            phase_nxt  = srrd_pkg::PH_START;
            if (b == srrd_pkg::EscByte) begin
              hc_nxt    = 1'b1;
              phase_nxt = srrd_pkg::PH_AFTER_ESC;
            end else begin
              held_nxt = b;
              if (in_item.last_in_row) begin
                cmd.r1_v = 1'b1;
                cmd.r1_x = {1'b0, b} + off;
              end else begin
                phase_nxt = srrd_pkg::PH_HELD;
              end
            end
          end else if (b == srrd_pkg::LongMark) begin
            phase_nxt = srrd_pkg::PH_LEN;
          end else begin
            cmd.r0_v   = 1'b1;
            cmd.r0_x   = {1'b0, held_r} + off;
            cmd.r0_len = b;
            phase_nxt  = srrd_pkg::PH_START;
          end
        end
        srrd_pkg::PH_LEN: begin
          cmd.r0_v   = 1'b1;
          cmd.r0_x   = {1'b0, held_r} + off;
          cmd.r0_len = b;
          phase_nxt  = srrd_pkg::PH_START;
        end
        default: begin
          phase_nxt = srrd_pkg::PH_START;
        end
      endcase
      if (in_item.last_in_row) begin
        cmd.row_end = 1'b1;
        phase_nxt   = srrd_pkg::PH_START;
        held_nxt    = 8'd0;
        hc_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= srrd_pkg::PH_START;
      held_r  <= 8'd0;
      hc_r    <= 1'b0;
    end else if (push) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      hc_r    <= hc_nxt;
    end
  end

endmodule

// ----- rtl/srrd_fifo.sv -----
// Short command queue between front and back end.
// Depends on srrd_pkg.
module srrd_fifo #(
  parameter int DEPTH = srrd_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  srrd_pkg::cmd_t push_data,
  input  logic           pop,
  output srrd_pkg::cmd_t head,
  output logic           not_empty,
  output logic           not_full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  srrd_pkg::cmd_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign not_empty = (count_r != '0);
  assign not_full  = (count_r != CntW'(DEPTH));
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- rtl/srrd_back.sv -----
// Back end: turns run commands into fill beats, tracks painted column.
// Depends on srrd_pkg.
module srrd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  srrd_pkg::cmd_t     cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  logic [9:0]         line_width,
  input  logic [15:0]        fg_colour,
  output logic               out_valid,
  input  logic               out_ready,
  output srrd_pkg::out_item_t out_item
);

  localparam int N = srrd_pkg::NumSlots;

  logic [N-1:0] mask_r, mask_nxt;
  logic [9:0]   cnt_r [N];
  logic [9:0]   cnt_nxt [N];
  logic         row_end_r;
  logic [10:0]  painted_r, painted_nxt;

  logic [10:0] x0, end0, p0, x1, end1, p1, lw_ext;
  logic        b0, c0, b1, c1, tr;
  logic [10:0] d0b, d0c, d1b, d1c, dt;

  logic [N-1:0] lowbit, rest;
  logic         fire, is_last;
  logic [9:0]   cnt_sel;

  assign lw_ext = {1'b0, line_width};
  assign x0     = {2'b00, cmd.r0_x};
  assign end0   = x0 + {3'b000, cmd.r0_len};
  assign b0     = cmd.r0_v && (painted_r < x0);
  assign c0     = cmd.r0_v && (painted_r < end0);
  assign p0     = c0 ? end0 : painted_r;
  assign d0b    = x0 - painted_r;
  assign d0c    = end0 - painted_r;
  assign x1     = {2'b00, cmd.r1_x};
  assign end1   = x1 + 11'd1;
  assign b1     = cmd.r1_v && (p0 < x1);
  assign c1     = cmd.r1_v && (p0 < end1);
  assign p1     = c1 ? end1 : p0;
  assign d1b    = x1 - p0;
  assign d1c    = end1 - p0;
  assign tr     = cmd.row_end && (p1 < lw_ext);
  assign dt     = lw_ext - p1;

  assign lowbit    = mask_r & (~mask_r + 1'b1);
  assign rest      = mask_r & ~lowbit;
  assign is_last   = (rest == '0);
  assign out_valid = (mask_r != '0);
  assign fire      = out_valid && out_ready;
  assign cmd_pop   = cmd_valid && (!out_valid || (fire && is_last));

  always_comb begin
    cnt_sel = '0;
    for (int i = 0; i < N; i++) begin
      if (lowbit[i]) begin
        cnt_sel = cnt_sel | cnt_r[i];
      end
    end
  end

  always_comb begin
    out_item.fill_count = cnt_sel;
    out_item.is_blank   = ((lowbit & srrd_pkg::BlankSlots) != '0);
    out_item.fill_value = out_item.is_blank ? 16'd0 : fg_colour;
    out_item.row_done   = is_last && row_end_r;
    out_item.last       = is_last;
  end

  always_comb begin
    mask_nxt   = mask_r;
    cnt_nxt[0] = d0b[9:0];
    cnt_nxt[1] = b0 ? {2'b00, cmd.r0_len} : d0c[9:0];
    cnt_nxt[2] = d1b[9:0];
    cnt_nxt[3] = b1 ? 10'd1 : d1c[9:0];
    cnt_nxt[4] = dt[9:0];
    painted_nxt = painted_r;
    if (cmd_pop) begin
      if (cmd.empty) begin
        mask_nxt    = 5'b10000;
        cnt_nxt[4]  = line_width;
        painted_nxt = '0;
      end else begin
        mask_nxt    = {tr, c1, b1, c0, b0};
        painted_nxt = cmd.row_end ? 11'd0 : p1;
      end
    end else if (fire) begin
      mask_nxt = mask_r & ~lowbit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      for (int i = 0; i < N; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      row_end_r <= cmd.empty || cmd.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= '0;
      painted_r <= '0;
    end else begin
      mask_r    <= mask_nxt;
      painted_r <= painted_nxt;
    end
  end

endmodule

// ----- rtl/sparse_run_row_decoder.sv -----
// Sparse run row decoder: code bytes in, display fill commands out, one
// item per beat on each side. The front end takes one byte per cycle while
// its command queue (QUEUE_DEPTH entries) has room; the back end sends one
// fill per cycle while out_ready is high, so an item holds the back end
// until its last fill is taken, and an item with no fill still takes its
// turn. Throughput is set by the back end's single fill port. Depends on
// srrd_pkg, srrd_front, srrd_fifo and srrd_back.
module sparse_run_row_decoder #(
  parameter int QUEUE_DEPTH = srrd_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  srrd_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output srrd_pkg::out_item_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [srrd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [srrd_pkg::CfgDataW-1:0] cfg_wdata
);

  logic [9:0]     line_width_r;
  logic [15:0]    fg_colour_r;
  logic           push, pop, q_not_empty, q_not_full;
  srrd_pkg::cmd_t f_cmd, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= srrd_pkg::LineWidthReset;
      fg_colour_r  <= srrd_pkg::FgColourReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        srrd_pkg::CFG_LINE_WIDTH: line_width_r <= cfg_wdata[9:0];
        srrd_pkg::CFG_FG_COLOUR:  fg_colour_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready = q_not_full;
  assign push     = in_valid && q_not_full;

  srrd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_data),
    .push    (push),
    .cmd     (f_cmd)
  );

  srrd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (f_cmd),
    .pop       (pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  srrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (q_head),
    .cmd_valid  (q_not_empty),
    .cmd_pop    (pop),
    .line_width (line_width_r),
    .fg_colour  (fg_colour_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_data)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for sparse_run_row_decoder.
// Models the run decoder in SystemVerilog, drives random and directed code rows
// with random handshake gaps, and checks every fill beat. Depends on srrd_pkg and sparse_run_row_decoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srrd_pkg::*;

  localparam int DrainCycles = 32;
  localparam int HoldOffCycles = 300;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_wr_en;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  sparse_run_row_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // decoder model state
  logic [9:0] lw_model;
  logic [15:0] colour_model;
  phase_t ph;
  logic [7:0] held_start;
  logic high_cols;
  logic [10:0] painted;
  out_item_t staged[NumSlots];
  int n_staged;

  out_item_t expected_fills[$];
  out_item_t want;
  bit mismatch_seen = 1'b0;
  int unsigned items_sent = 0;
  bit tx_fast = 1'b0;
  int unsigned rx_hold_cycles = 0;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_item_t mk_item(logic [7:0] code, logic lst, logic empty);
    in_item_t it;
    it.code_byte = code;
    it.last_in_row = lst;
    it.row_empty = empty;
    return it;
  endfunction

  function automatic void clear_row();
    ph = PH_START;
    held_start = 8'd0;
    high_cols = 1'b0;
    painted = 11'd0;
  endfunction

  function automatic void stage_fill(logic [10:0] cnt, logic blank);
    if (n_staged < NumSlots) begin
      staged[n_staged].fill_count = cnt[9:0];
      staged[n_staged].fill_value = blank ? 16'h0000 : colour_model;
      staged[n_staged].is_blank = blank;
      staged[n_staged].row_done = 1'b0;
      staged[n_staged].last = 1'b0;
      n_staged++;
    end
  endfunction

  function automatic void paint_run(logic [7:0] start, logic [7:0] len);
    logic [10:0] x;
    logic [10:0] stop;
    x = {3'b000, start} + (high_cols ? {2'b00, EscOffset} : 11'd0);
    stop = x + {3'b000, len};
    if (painted < x) begin
      stage_fill(x - painted, 1'b1);
      stage_fill({3'b000, len}, 1'b0);
      painted = stop;
    end else if (painted < stop) begin
      stage_fill(stop - painted, 1'b0);
      painted = stop;
    end
  endfunction

  function automatic void begin_entry(logic [7:0] b, logic lst);
    if (b == EscByte) begin
      high_cols = 1'b1;
      ph = PH_AFTER_ESC;
    end else begin
      held_start = b;
      if (lst) paint_run(b, 8'd1);
      else ph = PH_HELD;
    end
  endfunction

  function automatic void predict_fills(in_item_t it);
    n_staged = 0;
    if (it.row_empty) begin
      clear_row();
      stage_fill({1'b0, lw_model}, 1'b1);
      staged[0].row_done = 1'b1;
      staged[0].last = 1'b1;
    end else begin
      case (ph)
        PH_START: begin
          begin_entry(it.code_byte, it.last_in_row);
        end
        PH_AFTER_ESC: begin
          held_start = it.code_byte;
          if (it.last_in_row) paint_run(it.code_byte, 8'd1);
          else ph = PH_HELD;
        end
        PH_HELD: begin
          if (it.code_byte > held_start) begin
            paint_run(held_start, 8'd1);
            ph = PH_START;
            begin_entry(it.code_byte, it.last_in_row);
          end else if (it.code_byte == LongMark) begin
            ph = PH_LEN;
          end else begin
            paint_run(held_start, it.code_byte);
            ph = PH_START;
          end
        end
        default: begin
          paint_run(held_start, it.code_byte);
          ph = PH_START;
        end
      endcase
      if (it.last_in_row) begin
        if (painted < {1'b0, lw_model}) stage_fill({1'b0, lw_model} - painted, 1'b1);
        if (n_staged > 0) staged[n_staged-1].row_done = 1'b1;
        clear_row();
      end
      if (n_staged > 0) staged[n_staged-1].last = 1'b1;
    end
    for (int i = 0; i < n_staged; i++) expected_fills.push_back(staged[i]);
  endfunction

  // input beats feed the model, output beats are checked against it
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_fills(in_data);
    if (rst_n && out_valid && out_ready) begin
      if (expected_fills.size() == 0) begin
        $error("fill beat with nothing expected: count %0d value %h",
               out_data.fill_count, out_data.fill_value);
        mismatch_seen = 1'b1;
      end else begin
        want = expected_fills.pop_front();
        if (out_data.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, actual %0d", want.fill_count, out_data.fill_count);
          mismatch_seen = 1'b1;
        end
        if (out_data.fill_value !== want.fill_value) begin
          $error("fill_value: expected %h, actual %h", want.fill_value, out_data.fill_value);
          mismatch_seen = 1'b1;
        end
        if (out_data.is_blank !== want.is_blank) begin
          $error("is_blank: expected %0b, actual %0b", want.is_blank, out_data.is_blank);
          mismatch_seen = 1'b1;
        end
        if (out_data.row_done !== want.row_done) begin
          $error("row_done: expected %0b, actual %0b", want.row_done, out_data.row_done);
          mismatch_seen = 1'b1;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_data.last);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // fill sink: random wait before each beat, optional long hold-off
  initial begin
    int unsigned gap;
    bit rx_fast;
    rx_fast = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
      gap = rx_fast ? 0 : $urandom_range(0, 14);
      if (rx_hold_cycles != 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(in_item_t item);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_fills.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == CFG_LINE_WIDTH) lw_model = data[9:0];
    else colour_model = data;
  endtask

  // one row: mostly well-formed entries, sometimes an empty row, noise or a cut-off row
  task automatic send_random_row();
    logic [7:0] codes[$];
    int unsigned kind;
    int unsigned col;
    int unsigned n_entries;
    int unsigned cut;
    bit escaped;
    bit broken;
    logic [7:0] s;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      send_item(mk_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1));
    end else if (kind == 1) begin
      repeat ($urandom_range(1, 8))
        send_item(mk_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                          $urandom_range(0, 15) == 0));
    end else begin
      col = $urandom_range(0, 30);
      escaped = 1'b0;
      n_entries = $urandom_range(1, 5);
      for (int e = 0; e < n_entries; e++) begin
        if (!escaped && $urandom_range(0, 4) == 0) begin
          codes.push_back(EscByte);
          escaped = 1'b1;
          col = $urandom_range(0, 40);
        end
        col += $urandom_range(0, 70);
        if (col > 254) col = $urandom_range(200, 254);
        s = col[7:0];
        case ($urandom_range(0, 2))
          0: codes.push_back(s);
          1: begin
            codes.push_back(s);
            if (s != 8'd0) begin
              codes.push_back(8'($urandom_range(1, s)));
            end else begin
              codes.push_back(LongMark);
              codes.push_back(8'($urandom_range(0, 255)));
            end
          end
          default: begin
            codes.push_back(s);
            codes.push_back(LongMark);
            codes.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
      if ($urandom_range(0, 9) == 0) codes.push_back(EscByte);
      broken = ($urandom_range(0, 9) == 0);
      cut = broken ? $urandom_range(1, codes.size()) : codes.size();
      for (int i = 0; i < cut; i++)
        send_item(mk_item(codes[i], !broken && (i == codes.size() - 1), 1'b0));
      if (broken) send_item(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    end
  endtask

  task automatic test_directed_cases();
    tx_fast = 1'b0;
    send_item(mk_item(8'hA5, 1'b1, 1'b1));
    send_item(mk_item(8'h00, 1'b1, 1'b0));
    send_item(mk_item(8'h0A, 1'b0, 1'b0));
    send_item(mk_item(8'h14, 1'b1, 1'b0));
    // escape as the row's last byte
    send_item(mk_item(8'h05, 1'b0, 1'b0));
    send_item(mk_item(8'h02, 1'b0, 1'b0));
    send_item(mk_item(EscByte, 1'b1, 1'b0));
    // repeated escape, zero-length long run
    send_item(mk_item(EscByte, 1'b0, 1'b0));
    send_item(mk_item(8'h10, 1'b0, 1'b0));
    send_item(mk_item(8'h01, 1'b0, 1'b0));
    send_item(mk_item(EscByte, 1'b0, 1'b0));
    send_item(mk_item(8'h20, 1'b0, 1'b0));
    send_item(mk_item(LongMark, 1'b0, 1'b0));
    send_item(mk_item(8'h00, 1'b1, 1'b0));
    // 0xFF start after escape, row covered, ending byte yields nothing
    send_item(mk_item(EscByte, 1'b0, 1'b0));
    send_item(mk_item(8'hFF, 1'b0, 1'b0));
    send_item(mk_item(LongMark, 1'b0, 1'b0));
    send_item(mk_item(8'hFF, 1'b0, 1'b0));
    send_item(mk_item(EscByte, 1'b1, 1'b0));
    // zero marker as last byte
    send_item(mk_item(8'h30, 1'b0, 1'b0));
    send_item(mk_item(LongMark, 1'b1, 1'b0));
    // empty row cuts a row short
    send_item(mk_item(8'h40, 1'b0, 1'b0));
    send_item(mk_item(8'h50, 1'b0, 1'b0));
    send_item(mk_item(8'h5A, 1'b0, 1'b1));
    wait_drained();
  endtask

  task automatic test_backpressure();
    int unsigned target;
    target = items_sent + 25;
    rx_hold_cycles = HoldOffCycles;
    tx_fast = 1'b1;
    while (items_sent < target) send_random_row();
    tx_fast = 1'b0;
    wait_drained();
  endtask

  task automatic test_register_sweep();
    logic [15:0] w;
    logic [15:0] c;
    int unsigned target;
    for (int k = 0; k < 5; k++) begin
      w = 16'($urandom);
      c = 16'($urandom);
      case (k)
        0: begin
          w[9:0] = 10'd1023;
          c = 16'h0000;
        end
        1: begin
          w[9:0] = 10'd1;
          c = 16'hFFFF;
        end
        2: w[9:0] = 10'd0;
        3: w[9:0] = 10'($urandom_range(1, 1023));
        default: w[9:0] = 10'($urandom_range(100, 400));
      endcase
      write_reg(CFG_LINE_WIDTH, w);
      write_reg(CFG_FG_COLOUR, c);
      target = items_sent + 48;
      while (items_sent < target) begin
        tx_fast = ($urandom_range(0, 3) == 0);
        send_random_row();
      end
      wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    lw_model = LineWidthReset;
    colour_model = FgColourReset;
    clear_row();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_directed_cases();
    test_backpressure();
    test_register_sweep();
    wait_drained();
    if (!mismatch_seen) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/srrd_pkg.sv
rtl/srrd_front.sv
rtl/srrd_fifo.sv
rtl/srrd_back.sv
rtl/sparse_run_row_decoder.sv
tb/tb.sv
